// File: design/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    typedef struct packed {
        logic               op;
        logic [15:0]        item_handle;
        logic signed [15:0] item_kind;
        logic signed [15:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [OCC_W-1:0]   occupancy;
        logic [15:0]        out_handle;
        logic signed [15:0] out_kind;
        logic signed [15:0] out_priority;
    } rsp_t;

    typedef struct packed {
        logic [15:0]        handle;
        logic signed [15:0] kind;
        logic signed [15:0] prio;
    } entry_t;

    typedef struct packed {
        logic hit;   // stored handle equals the key handle
        logic le;    // stored priority <= key priority
    } cmp_t;

endpackage

// File: design/spq_cmp.sv
module spq_cmp
    import spq_pkg::*;
(
    input  entry_t             slot,
    input  logic [15:0]        key_handle,
    input  logic signed [15:0] key_prio,
    output cmp_t               result
);

    always_comb
    begin
        result.hit = (slot.handle == key_handle);
        result.le  = (slot.prio <= key_prio);
    end

endmodule

// File: design/stable_priority_queue.sv
// Insert (N queued, P insert slot) scans all N entries for a duplicate handle and for P,
//   then shifts entries P..N-1 one slot down and writes the new one; an empty queue skips both.
//   A duplicate is rejected after the scan; a zero handle, a full queue and a remove on empty without one.
// One operation at a time: a new request is taken only once the result is registered and the block is idle;
//   a stalled result holds the block until it leaves.
// Reset (async, active low) empties the queue and drops any pending result; slots are not cleared.
module stable_priority_queue
    import spq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_POP   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             dup_reg, dup_next;
    req_t             key_reg, key_next;
    rsp_t             res_reg, res_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    entry_t           mem [CAPACITY];
    entry_t           mem_q;
    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    entry_t           wr_data;

    cmp_t             cmp;
    logic             cmp_valid;
    logic             dup_scan;
    logic [CNT_W-1:0] pos_scan;
    logic [CNT_W-1:0] idx_inc, idx_dec, idx_dec2, cnt_inc, cnt_dec;

    spq_cmp u_cmp (
        .slot       (mem_q),
        .key_handle (key_reg.item_handle),
        .key_prio   (key_reg.priority_req),
        .result     (cmp)
    );

    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign idx_dec2 = idx_reg - CNT_W'(2);
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign cnt_dec  = cnt_reg - CNT_W'(1);

    // mem_q holds entry idx-1 once the scan has issued its first read
    assign cmp_valid = (idx_reg != '0);
    assign dup_scan  = dup_reg | (cmp_valid & cmp.hit);
    assign pos_scan  = pos_reg + CNT_W'(cmp_valid & cmp.le);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        dup_next       = dup_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = mem_q;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next = req;
                    dup_next = 1'b0;
                    pos_next = '0;
                    idx_next = '0;
                    res_next = '0;
                    res_next.occupancy = OCC_W'(cnt_reg);
                    if (req.op == OP_INSERT)
                    begin
                        if (req.item_handle == '0 || cnt_reg == CNT_W'(CAPACITY))
                        begin
                            res_next.status = ST_REJECT;
                            state_next      = S_DONE;
                        end
                        else if (cnt_reg == '0)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg < cnt_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_reg[IDX_W-1:0];
                end
                dup_next = dup_scan;
                pos_next = pos_scan;
                if (idx_reg == cnt_reg)
                begin
                    if (dup_scan)
                    begin
                        res_next.status = ST_REJECT;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next   = cnt_reg;
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_SHIFT:
            begin
                // read slot idx-1 while writing the previous read one slot down
                if (idx_reg > pos_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_dec[IDX_W-1:0];
                    idx_next = idx_dec;
                end
                if (idx_reg < cnt_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_inc[IDX_W-1:0];
                end
                if (idx_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                wr_en          = 1'b1;
                wr_addr        = pos_reg[IDX_W-1:0];
                wr_data.handle = key_reg.item_handle;
                wr_data.kind   = key_reg.item_kind;
                wr_data.prio   = key_reg.priority_req;
                cnt_next       = cnt_inc;
                res_next.status    = ST_OK;
                res_next.occupancy = OCC_W'(cnt_inc);
                state_next     = S_DONE;
            end
            S_POP:
            begin
                if (idx_reg < cnt_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_reg[IDX_W-1:0];
                end
                if (idx_reg == CNT_W'(1))
                begin
                    res_next.out_handle   = mem_q.handle;
                    res_next.out_kind     = mem_q.kind;
                    res_next.out_priority = mem_q.prio;
                end
                if (idx_reg > CNT_W'(1))
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_dec2[IDX_W-1:0];
                end
                if (idx_reg == cnt_reg)
                begin
                    cnt_next           = cnt_dec;
                    res_next.status    = ST_OK;
                    res_next.occupancy = OCC_W'(cnt_dec);
                    state_next         = S_DONE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            dup_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            dup_reg       <= dup_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> ($past(state_reg) == S_PUT || $past(state_reg) == S_POP))
        else $error("entry count changed outside put or pop");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == ST_EMPTY |-> rsp_reg.occupancy == '0)
        else $error("empty status with nonzero occupancy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status != ST_OK |-> rsp_reg.out_handle == '0)
        else $error("failed operation returned a handle");
`endif

endmodule
